// ----- design/pvrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PIN verify package
// Shared types and constants of the PIN checker with try counter.
// ----------------------------------------------------------------------------
package pvrc_pkg;

  localparam int LEN_W      = 4;
  localparam int TRIES_W    = 4;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int FIELD_PIN_W = 64;

  localparam logic [7:0] REF_APP    = 8'h80;
  localparam logic [7:0] REF_GLOBAL = 8'h00;

  localparam int DEFAULT_LEN = 6;
  localparam logic [7:0] DEFAULT_DIGITS [DEFAULT_LEN] =
    '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

  typedef enum logic [1:0] {
    CMD_STATUS  = 2'd0,
    CMD_VERIFY  = 2'd1,
    CMD_CHANGE  = 2'd2,
    CMD_FACTORY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SUCCESS     = 3'd0,
    ST_WRONG       = 3'd1,
    ST_BAD_REF     = 3'd2,
    ST_BLOCKED     = 3'd3,
    ST_SEC_NOT_SAT = 3'd4,
    ST_WRONG_LEN   = 3'd5
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] retry_limit;
    logic [CFG_W-1:0] min_pin_length;
    logic [CFG_W-1:0] max_pin_length;
  } cfg_t;

  typedef struct packed {
    cmd_t                   command;
    logic [7:0]             pin_reference;
    logic [FIELD_PIN_W-1:0] entered_pin;
    logic [LEN_W-1:0]       entered_length;
    logic [FIELD_PIN_W-1:0] new_pin_value;
    logic [LEN_W-1:0]       new_length;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [TRIES_W-1:0]   tries_left;
    logic                 verified;
  } res_t;

endpackage
`default_nettype wire

// ----- design/pvrc_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PIN verify configuration registers
// Retry limit and PIN length bounds, written through a plain write port.
// ----------------------------------------------------------------------------
module pvrc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pvrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pvrc_pkg::CFG_W-1:0]     cfg_wdata,
  output pvrc_pkg::cfg_t                      cfg
);
  import pvrc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_RETRY_LIMIT: cfg_nxt.retry_limit    = cfg_wdata;
        CFG_MIN_LEN:     cfg_nxt.min_pin_length = cfg_wdata;
        CFG_MAX_LEN:     cfg_nxt.max_pin_length = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit    <= CFG_W'(3);
      cfg_r.min_pin_length <= CFG_W'(6);
      cfg_r.max_pin_length <= CFG_W'(8);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- design/pvrc_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PIN verify engine
// Holds the stored PIN, its length, the try counter and the verified flag,
// and decides one command per cycle, updating its state only while item_en is high.
// ----------------------------------------------------------------------------
module pvrc_engine #(
  parameter int PIN_BYTES = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_en,
  input  wire pvrc_pkg::item_t item,
  input  wire pvrc_pkg::cfg_t  cfg,
  output pvrc_pkg::res_t       res
);
  import pvrc_pkg::*;

  localparam int PinW   = 8 * PIN_BYTES;
  localparam int DefLen = (PIN_BYTES < DEFAULT_LEN) ? PIN_BYTES : DEFAULT_LEN;
  localparam logic [LEN_W-1:0] PinBytesL = LEN_W'(PIN_BYTES);
  localparam logic [LEN_W-1:0] DefLenL   = LEN_W'(DefLen);

  function automatic logic [PinW-1:0] factory_pin_value();
    logic [PinW-1:0] p;
    p = '0;
    for (int i = 0; i < DefLen; i++) begin
      p[8*i +: 8] = DEFAULT_DIGITS[i];
    end
    return p;
  endfunction

  localparam logic [PinW-1:0] DefPin = factory_pin_value();

  logic [PinW-1:0]    pin_r, pin_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [TRIES_W-1:0] tries_r, tries_nxt;
  logic               ok_r, ok_nxt;
  status_t            status;

  logic            ref_ok;
  logic            match;
  logic            new_len_ok;
  logic [PinW-1:0] new_pin;

  assign ref_ok = (item.pin_reference == REF_APP) || (item.pin_reference == REF_GLOBAL);

  always_comb begin
    match = (item.entered_length <= PinBytesL) && (item.entered_length == len_r);
    for (int i = 0; i < PIN_BYTES; i++) begin
      if ((LEN_W'(i) < item.entered_length) &&
          (item.entered_pin[8*i +: 8] != pin_r[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PIN_BYTES; i++) begin
      new_pin[8*i +: 8] = (LEN_W'(i) < item.new_length) ? item.new_pin_value[8*i +: 8] : 8'h00;
    end
  end

  assign new_len_ok = (item.new_length >= cfg.min_pin_length) &&
                      (item.new_length <= cfg.max_pin_length) &&
                      (item.new_length <= PinBytesL);

  always_comb begin
    pin_nxt   = pin_r;
    len_nxt   = len_r;
    tries_nxt = tries_r;
    ok_nxt    = ok_r;
    status    = ST_SUCCESS;
    case (item.command)
      CMD_STATUS: begin
        status = ok_r ? ST_SUCCESS : ST_WRONG;
      end
      CMD_VERIFY: begin
        if (!ref_ok) begin
          status = ST_BAD_REF;
        end else if (tries_r == '0) begin
          status = ST_BLOCKED;
        end else if (match) begin
          ok_nxt    = 1'b1;
          tries_nxt = cfg.retry_limit;
          status    = ST_SUCCESS;
        end else begin
          ok_nxt    = 1'b0;
          tries_nxt = tries_r - TRIES_W'(1);
          status    = ST_WRONG;
        end
      end
      CMD_CHANGE: begin
        if (!ref_ok) begin
          status = ST_BAD_REF;
        end else if (!ok_r || !match) begin
          status = ST_SEC_NOT_SAT;
        end else if (!new_len_ok) begin
          status = ST_WRONG_LEN;
        end else begin
          pin_nxt = new_pin;
          len_nxt = item.new_length;
          status  = ST_SUCCESS;
        end
      end
      CMD_FACTORY: begin
        pin_nxt   = DefPin;
        len_nxt   = DefLenL;
        tries_nxt = cfg.retry_limit;
        ok_nxt    = 1'b0;
        status    = ST_SUCCESS;
      end
      default: begin
        status = ST_SUCCESS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r   <= DefPin;
      len_r   <= DefLenL;
      tries_r <= TRIES_W'(3);
      ok_r    <= 1'b0;
    end else if (item_en) begin
      pin_r   <= pin_nxt;
      len_r   <= len_nxt;
      tries_r <= tries_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign res.status     = status;
  assign res.tries_left = tries_nxt;
  assign res.verified   = ok_nxt;

  a_factory_restores: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && (item.command == CMD_FACTORY) |=>
      !ok_r && (tries_r == $past(cfg.retry_limit)) && (len_r == DefLenL))
    else $error("factory reset did not restore tries, flag or length");

  a_miss_uses_try: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && (item.command == CMD_VERIFY) && (status == ST_WRONG) |=>
      !ok_r && (tries_r == $past(tries_r) - TRIES_W'(1)))
    else $error("wrong PIN did not use exactly one try");

  a_change_keeps_tries: assert property (@(posedge clk) disable iff (!rst_n)
    item_en && (item.command == CMD_CHANGE) |=>
      (ok_r == $past(ok_r)) && (tries_r == $past(tries_r)))
    else $error("change command altered tries or verified flag");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= PinBytesL)
    else $error("stored PIN length beyond storage");

endmodule
`default_nettype wire

// ----- design/pin_verify_retry_counter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PIN verify retry counter core
// PIN checker with try counter: status, verify, change and factory reset.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | sink      | one command beat: tuser command, tdata arguments
// out_    | source    | one result beat per command
// cfg_    | write     | retry_limit (0), min_pin_length (1), max_pin_length (2)
//
// The engine decides a command combinationally between the input register
// and the result register, so one beat is accepted every cycle when out_tready
// is high. A result is registered when its command advances from the input
// register, and leaves through out_ while out_tready is high.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds the engine; in_tready falls only when both stages are full.
// ----------------------------------------------------------------------------
module pin_verify_retry_counter_core #(
  parameter int PIN_BYTES = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // pin_reference[7:0], entered_pin[71:8], entered_length[75:72],
  // new_pin_value[139:76], new_length[143:140]
  input  wire logic [143:0]                   in_tdata,
  // command[1:0]
  input  wire logic [1:0]                     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // status[2:0], tries_left[6:3], verified[7]
  output logic [7:0]                          out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [pvrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pvrc_pkg::CFG_W-1:0]     cfg_wdata
);
  import pvrc_pkg::*;

  logic  in_valid_r;
  item_t in_item_r;
  logic  out_valid_r;
  res_t  out_res_r;
  logic  adv;
  logic  in_acc;
  item_t item_in;
  cfg_t  cfg;
  res_t  res;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign item_in.command        = cmd_t'(in_tuser);
  assign item_in.pin_reference  = in_tdata[7:0];
  assign item_in.entered_pin    = in_tdata[71:8];
  assign item_in.entered_length = in_tdata[75:72];
  assign item_in.new_pin_value  = in_tdata[139:76];
  assign item_in.new_length     = in_tdata[143:140];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  pvrc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pvrc_engine #(
    .PIN_BYTES (PIN_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (adv),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.verified, out_res_r.tries_left, out_res_r.status};

endmodule
`default_nettype wire

// ----- tb/sv/pin_verify_retry_counter_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PIN verify retry counter core test
// Sends command beats into the core and checks every result beat against a
// model of the card kept in the bench: stored PIN and length, try count and
// verified flag. A directed script walks the corner cases, then random phases
// under several register settings follow, with random gaps on both channels
// and one long result stall that backs the core up into its input.
// ----------------------------------------------------------------------------
module pin_verify_retry_counter_core_test;
  import pvrc_pkg::*;

  localparam int PIN_BYTES = 8;
  localparam logic [63:0] FACTORY_PIN = 64'h0000_3635_3433_3231;
  localparam logic [3:0] FACTORY_LEN = 4'd6;
  localparam logic [63:0] ONES = '1;
  localparam int PHASE_BEATS = 142;
  localparam int PHASES = 6;

  typedef struct {
    bit    is_cfg;
    cfg_t  regs;
    item_t beat;
    bit    typed;
    res_t  answer;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid;
  logic in_tready;
  logic [143:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [7:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  logic [63:0] card_pin;
  logic [3:0] card_len;
  logic [3:0] card_tries;
  logic card_ok;
  cfg_t card_cfg;

  res_t pending_answers[$];
  int mismatches = 0;
  bit typed_on = 1'b0;
  res_t typed_answer;
  bit sender_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit sink_hold = 1'b0;

  pin_verify_retry_counter_core #(.PIN_BYTES(PIN_BYTES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] byte_span(input logic [3:0] n);
    if (n >= 8) return ONES;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic bit pin_hit(input logic [63:0] pin, input logic [3:0] len);
    if (len > PIN_BYTES || len != card_len) return 1'b0;
    return (pin & byte_span(len)) == (card_pin & byte_span(len));
  endfunction

  function automatic res_t run_command(input item_t b);
    res_t r;
    status_t st;
    bit bad_ref;
    st = ST_SUCCESS;
    bad_ref = b.pin_reference != REF_APP && b.pin_reference != REF_GLOBAL;
    case (b.command)
      CMD_STATUS: st = card_ok ? ST_SUCCESS : ST_WRONG;
      CMD_VERIFY: begin
        if (bad_ref) begin
          st = ST_BAD_REF;
        end else if (card_tries == 0) begin
          st = ST_BLOCKED;
        end else if (pin_hit(b.entered_pin, b.entered_length)) begin
          card_ok = 1'b1;
          card_tries = card_cfg.retry_limit;
        end else begin
          card_ok = 1'b0;
          card_tries = card_tries - 4'd1;
          st = ST_WRONG;
        end
      end
      CMD_CHANGE: begin
        if (bad_ref) begin
          st = ST_BAD_REF;
        end else if (!card_ok || !pin_hit(b.entered_pin, b.entered_length)) begin
          st = ST_SEC_NOT_SAT;
        end else if (b.new_length < card_cfg.min_pin_length ||
                     b.new_length > card_cfg.max_pin_length || b.new_length > PIN_BYTES) begin
          st = ST_WRONG_LEN;
        end else begin
          card_pin = b.new_pin_value & byte_span(b.new_length);
          card_len = b.new_length;
        end
      end
      default: begin
        card_pin = FACTORY_PIN;
        card_len = FACTORY_LEN;
        card_tries = card_cfg.retry_limit;
        card_ok = 1'b0;
      end
    endcase
    r.status = st;
    r.tries_left = card_tries;
    r.verified = card_ok;
    return r;
  endfunction

  function automatic item_t random_beat();
    item_t b;
    logic [63:0] span;
    int pick;
    pick = $urandom_range(0, 99);
    b.command = pick < 40 ? CMD_VERIFY : pick < 72 ? CMD_CHANGE :
                pick < 88 ? CMD_STATUS : CMD_FACTORY;
    pick = $urandom_range(0, 19);
    b.pin_reference = pick < 9 ? REF_APP : pick < 18 ? REF_GLOBAL : 8'($urandom_range(0, 255));
    b.entered_pin = {$urandom, $urandom};
    b.entered_length = 4'($urandom_range(0, 15));
    b.new_pin_value = {$urandom, $urandom};
    b.new_length = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      span = byte_span(card_len);
      b.entered_pin = (b.entered_pin & ~span) | (card_pin & span);
      b.entered_length = card_len;
    end else if (pick < 9 && card_len != 0) begin
      b.entered_pin = card_pin ^ (64'd1 << $urandom_range(0, 8 * card_len - 1));
      b.entered_length = card_len;
    end
    if ($urandom_range(0, 3) != 0 && card_cfg.min_pin_length <= card_cfg.max_pin_length &&
        card_cfg.max_pin_length <= PIN_BYTES) begin
      b.new_length = 4'($urandom_range(card_cfg.min_pin_length, card_cfg.max_pin_length));
    end
    return b;
  endfunction

  function automatic step_t row(input cmd_t c, input logic [7:0] pr, input logic [63:0] ep,
                                input logic [3:0] el, input logic [63:0] np,
                                input logic [3:0] nl, input bit typed, input status_t st,
                                input logic [3:0] tl, input logic vf);
    step_t s;
    s.is_cfg = 1'b0;
    s.regs = '0;
    s.beat = {c, pr, ep, el, np, nl};
    s.typed = typed;
    s.answer = {st, tl, vf};
    return s;
  endfunction

  function automatic step_t regs_row(input logic [3:0] lim, input logic [3:0] mn,
                                     input logic [3:0] mx);
    step_t s;
    s = row(CMD_STATUS, 8'h00, '0, '0, '0, '0, 1'b0, ST_SUCCESS, 4'd0, 1'b0);
    s.is_cfg = 1'b1;
    s.regs = {lim, mn, mx};
    return s;
  endfunction

  task automatic send_beat(input item_t b, input bit typed, input res_t answer);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_on = typed;
    typed_answer = answer;
    in_tuser <= b.command;
    in_tdata <= {b.new_length, b.new_pin_value, b.entered_length, b.entered_pin,
                 b.pin_reference};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic load_regs(input cfg_t regs);
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= regs.retry_limit;
    @(negedge clk);
    cfg_index <= CFG_MIN_LEN;
    cfg_wdata <= regs.min_pin_length;
    @(negedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_wdata <= regs.max_pin_length;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input and result beats are both taken at the same edge, in this order.
  always @(posedge clk) begin : watch
    item_t seen;
    res_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RETRY_LIMIT: card_cfg.retry_limit = cfg_wdata;
          CFG_MIN_LEN:     card_cfg.min_pin_length = cfg_wdata;
          CFG_MAX_LEN:     card_cfg.max_pin_length = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        seen = {in_tuser, in_tdata[7:0], in_tdata[71:8], in_tdata[75:72], in_tdata[139:76],
                in_tdata[143:140]};
        want = run_command(seen);
        if (typed_on) want = typed_answer;
        pending_answers.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: result beat %h arrived with nothing expected", $time, out_tdata);
        end else begin
          want = pending_answers.pop_front();
          if (out_tdata[2:0] !== want.status || out_tdata[6:3] !== want.tries_left ||
              out_tdata[7] !== want.verified) begin
            mismatches++;
            if (mismatches <= 40)
              $display("%0t: expected status %0d tries %0d verified %0d, got %0d %0d %0d",
                       $time, want.status, want.tries_left, want.verified,
                       out_tdata[2:0], out_tdata[6:3], out_tdata[7]);
          end
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 13);
      if (sink_hold) begin
        stall = 90;
        sink_hold = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && rst_n));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    step_t script[$];
    cfg_t plan[PHASES];
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    card_pin = FACTORY_PIN;
    card_len = FACTORY_LEN;
    card_cfg = {4'd3, 4'd6, 4'd8};
    card_tries = 4'd3;
    card_ok = 1'b0;
    plan[0] = {4'd3, 4'd6, 4'd8};
    plan[1] = {4'd1, 4'd1, 4'd8};
    plan[2] = {4'd15, 4'd8, 4'd8};
    plan[3] = {4'd7, 4'd4, 4'd5};
    plan[4] = {4'd2, 4'd1, 4'd1};
    plan[5] = {4'd15, 4'd1, 4'd8};

    script.push_back(row(CMD_STATUS, 8'hFF, '0, 4'd0, '0, 4'd0, 1'b1, ST_WRONG, 4'd3, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_APP, FACTORY_PIN, 4'd6, '0, 4'd0,
                         1'b1, ST_SUCCESS, 4'd3, 1'b1));
    script.push_back(row(CMD_STATUS, REF_GLOBAL, ONES, 4'd15, ONES, 4'd15,
                         1'b1, ST_SUCCESS, 4'd3, 1'b1));
    script.push_back(row(CMD_CHANGE, REF_GLOBAL, FACTORY_PIN, 4'd6, ONES, 4'd8,
                         1'b1, ST_SUCCESS, 4'd3, 1'b1));
    script.push_back(row(CMD_VERIFY, REF_APP, FACTORY_PIN, 4'd6, '0, 4'd0,
                         1'b1, ST_WRONG, 4'd2, 1'b0));
    script.push_back(row(CMD_VERIFY, 8'h7F, ONES, 4'd8, '0, 4'd0, 1'b1, ST_BAD_REF, 4'd2, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_GLOBAL, ONES, 4'd8, '0, 4'd0,
                         1'b1, ST_SUCCESS, 4'd3, 1'b1));
    script.push_back(row(CMD_CHANGE, REF_APP, ONES, 4'd15, '0, 4'd6,
                         1'b1, ST_SEC_NOT_SAT, 4'd3, 1'b1));
    script.push_back(row(CMD_CHANGE, REF_APP, ONES, 4'd8, ONES, 4'd5,
                         1'b1, ST_WRONG_LEN, 4'd3, 1'b1));
    script.push_back(row(CMD_CHANGE, REF_APP, ONES, 4'd8, '0, 4'd9,
                         1'b1, ST_WRONG_LEN, 4'd3, 1'b1));
    script.push_back(row(CMD_CHANGE, 8'h01, ONES, 4'd8, '0, 4'd6, 1'b1, ST_BAD_REF, 4'd3, 1'b1));
    script.push_back(row(CMD_VERIFY, REF_APP, ONES, 4'd15, '0, 4'd0, 1'b1, ST_WRONG, 4'd2, 1'b0));
    script.push_back(row(CMD_CHANGE, REF_APP, ONES, 4'd8, '0, 4'd6,
                         1'b1, ST_SEC_NOT_SAT, 4'd2, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_APP, '0, 4'd8, '0, 4'd0, 1'b1, ST_WRONG, 4'd1, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_APP, '0, 4'd0, '0, 4'd0, 1'b1, ST_WRONG, 4'd0, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_APP, ONES, 4'd8, '0, 4'd0, 1'b1, ST_BLOCKED, 4'd0, 1'b0));
    script.push_back(row(CMD_FACTORY, 8'hFF, ONES, 4'd15, ONES, 4'd15,
                         1'b1, ST_SUCCESS, 4'd3, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_GLOBAL, 64'hA5A5_3635_3433_3231, 4'd6, '0, 4'd0,
                         1'b0, ST_SUCCESS, 4'd0, 1'b0));
    script.push_back(row(CMD_CHANGE, REF_APP, FACTORY_PIN, 4'd6, 64'h0123_4567_89AB_CDEF, 4'd7,
                         1'b0, ST_SUCCESS, 4'd0, 1'b0));
    script.push_back(regs_row(4'd3, 4'd0, 4'd8));
    script.push_back(row(CMD_CHANGE, REF_APP, 64'hFF23_4567_89AB_CDEF, 4'd7, ONES, 4'd0,
                         1'b0, ST_SUCCESS, 4'd0, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_APP, ONES, 4'd0, '0, 4'd0, 1'b0, ST_SUCCESS, 4'd0, 1'b0));
    script.push_back(regs_row(4'd0, 4'd7, 4'd3));
    script.push_back(row(CMD_VERIFY, REF_GLOBAL, '0, 4'd0, '0, 4'd0,
                         1'b0, ST_SUCCESS, 4'd0, 1'b0));
    script.push_back(row(CMD_CHANGE, REF_APP, '0, 4'd0, ONES, 4'd7, 1'b0, ST_SUCCESS, 4'd0, 1'b0));
    script.push_back(row(CMD_FACTORY, REF_APP, '0, 4'd0, '0, 4'd0, 1'b1, ST_SUCCESS, 4'd0, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_APP, FACTORY_PIN, 4'd6, '0, 4'd0,
                         1'b1, ST_BLOCKED, 4'd0, 1'b0));
    script.push_back(regs_row(4'd15, 4'd6, 4'd8));
    script.push_back(row(CMD_FACTORY, REF_APP, '0, 4'd0, '0, 4'd0,
                         1'b1, ST_SUCCESS, 4'd15, 1'b0));
    script.push_back(row(CMD_VERIFY, REF_APP, FACTORY_PIN, 4'd6, '0, 4'd0,
                         1'b1, ST_SUCCESS, 4'd15, 1'b1));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) load_regs(script[i].regs);
      else send_beat(script[i].beat, script[i].typed, script[i].answer);
    end

    for (int p = 0; p < PHASES; p++) begin
      load_regs(plan[p]);
      sender_calm = (p == 0) || (p == PHASES - 1);
      sink_calm = (p == PHASES - 1);
      if (p == 0) sink_hold = 1'b1;
      repeat (PHASE_BEATS) send_beat(random_beat(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- pin_verify_retry_counter_core.f -----
design/pvrc_pkg.sv
design/pvrc_cfg.sv
design/pvrc_engine.sv
design/pin_verify_retry_counter_core.sv
tb/sv/pin_verify_retry_counter_core_test.sv
